// File: rtl/vml_pkg.sv
// Shared widths and pipeline data types for the vector magnitude limiter.
// Used by the square-root cells, the divider cells and the top level.
package vml_pkg;

	localparam int COMP_WIDTH = 32;
	localparam int CW   = COMP_WIDTH;
	localparam int SW   = 31;
	localparam int MW   = 2 * CW;
	localparam int PW   = CW + SW;
	localparam int AW   = PW + 2;
	localparam int HW   = AW - CW;
	localparam int LW2  = 2 * SW;
	localparam int KW   = (MW > LW2) ? MW : LW2;
	localparam int RW   = CW + 2;

	typedef struct packed {
		logic [2:0][CW-1:0] c;
		logic [2:0]         neg;
		logic               lim;
		logic [2:0][PW-1:0] p;
		logic [MW-1:0]      n;
		logic [RW-1:0]      rem;
		logic [CW-1:0]      root;
	} sq_t;

	typedef struct packed {
		logic [2:0][CW-1:0] c;
		logic [2:0]         neg;
		logic               lim;
		logic [CW-1:0]      s;
		logic [2:0][AW-1:0] a;
	} dv_t;

endpackage

// File: rtl/vml_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
// Depends on vml_pkg for the sq_t stage record.
module vml_sqrt_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  vml_pkg::sq_t in_d,
	output logic         out_valid,
	output vml_pkg::sq_t out_d
);

	logic [vml_pkg::RW+1:0] rem2;
	logic [vml_pkg::RW+1:0] trial;
	logic                   ge;
	vml_pkg::sq_t           nxt;
	logic                   valid_q;
	vml_pkg::sq_t           d_q;

	always_comb begin
		rem2  = {in_d.rem, in_d.n[vml_pkg::MW-1 -: 2]};
		trial = {2'b00, in_d.root, 2'b01};
		ge    = rem2 >= trial;
		nxt   = in_d;
		nxt.n = {in_d.n[vml_pkg::MW-3:0], 2'b00};
		nxt.rem = ge ? vml_pkg::RW'(rem2 - trial) : vml_pkg::RW'(rem2);
		nxt.root = {in_d.root[vml_pkg::CW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_d     = d_q;

endmodule

// File: rtl/vml_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider, three lanes.
// Depends on vml_pkg for the dv_t stage record.
module vml_div_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  vml_pkg::dv_t in_d,
	output logic         out_valid,
	output vml_pkg::dv_t out_d
);

	logic [2:0][vml_pkg::AW-1:0] sh;
	logic [2:0][vml_pkg::HW-1:0] hi;
	logic [2:0]                  ge;
	vml_pkg::dv_t                nxt;
	logic                        valid_q;
	vml_pkg::dv_t                d_q;

	always_comb begin
		nxt = in_d;
		for (int i = 0; i < 3; i++) begin
			sh[i] = {in_d.a[i][vml_pkg::AW-2:0], 1'b0};
			hi[i] = sh[i][vml_pkg::AW-1:vml_pkg::CW];
			ge[i] = hi[i] >= vml_pkg::HW'(in_d.s);
			nxt.a[i] = {(ge[i] ? hi[i] - vml_pkg::HW'(in_d.s) : hi[i]),
				sh[i][vml_pkg::CW-1:1], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_d     = d_q;

endmodule

// File: rtl/vector_magnitude_limiter.sv
// Vector magnitude limiter: registered input stages, then one square-root cell and one
// divider cell per result bit, then a registered output stage.
// Throughput: one request per cycle; busy is always low, done strobes one cycle.
// Reset clears all valid flags and sets max_speed to zero.
// Depends on vml_pkg, vml_sqrt_cell and vml_div_cell.
module vector_magnitude_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [31:0]            vel_x,
	input  logic signed [31:0]            vel_y,
	input  logic signed [31:0]            vel_z,
	input  logic                          bypass,
	input  logic                          cfg_we,
	input  logic [vml_pkg::SW-1:0]        cfg_wdata,
	output logic                          done,
	output logic signed [31:0]            out_x,
	output logic signed [31:0]            out_y,
	output logic signed [31:0]            out_z,
	output logic                          was_limited
);

	localparam int CW = vml_pkg::CW;

	logic [vml_pkg::SW-1:0]          max_speed_q;
	logic [2:0][CW-1:0]              raw;

	logic                            v_s1;
	logic [2:0][CW-1:0]              c_s1;
	logic [2:0][CW-1:0]              m_s1;
	logic [2:0]                      neg_s1;
	logic                            byp_s1;
	logic [vml_pkg::SW-1:0]          lim_s1;

	logic                            v_s2;
	logic [2:0][CW-1:0]              c_s2;
	logic [2:0]                      neg_s2;
	logic                            byp_s2;
	logic [2:0][vml_pkg::MW-1:0]     sq_s2;
	logic [2:0][vml_pkg::PW-1:0]     p_s2;
	logic [vml_pkg::LW2-1:0]         lim2_s2;

	logic                            v_s3;
	logic [2:0][CW-1:0]              c_s3;
	logic [2:0]                      neg_s3;
	logic                            byp_s3;
	logic [2:0][vml_pkg::PW-1:0]     p_s3;
	logic [vml_pkg::MW-1:0]          mag2_s3;
	logic [vml_pkg::LW2-1:0]         lim2_s3;

	logic                            v_s4;
	vml_pkg::sq_t                    sq_s4;

	logic [CW:0]                     sq_v;
	vml_pkg::sq_t [CW:0]             sq_d;
	logic [CW:0]                     dv_v;
	vml_pkg::dv_t [CW:0]             dv_d;

	logic [2:0][CW-1:0]              res;
	logic                            done_q;
	logic [2:0][31:0]                out_q;
	logic                            lim_q;

	assign busy = 1'b0;
	assign raw[0] = vel_x[CW-1:0];
	assign raw[1] = vel_y[CW-1:0];
	assign raw[2] = vel_z[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= '0;
		end else if (cfg_we) begin
			max_speed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= dv_v[CW];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			c_s1[i]   <= raw[i];
			neg_s1[i] <= raw[i][CW-1];
			m_s1[i]   <= raw[i][CW-1] ? CW'(-raw[i]) : raw[i];
		end
		byp_s1 <= bypass;
		lim_s1 <= max_speed_q;

		c_s2    <= c_s1;
		neg_s2  <= neg_s1;
		byp_s2  <= byp_s1;
		lim2_s2 <= vml_pkg::LW2'(lim_s1) * vml_pkg::LW2'(lim_s1);
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= vml_pkg::MW'(m_s1[i]) * vml_pkg::MW'(m_s1[i]);
			p_s2[i]  <= vml_pkg::PW'(m_s1[i]) * vml_pkg::PW'(lim_s1);
		end

		c_s3    <= c_s2;
		neg_s3  <= neg_s2;
		byp_s3  <= byp_s2;
		p_s3    <= p_s2;
		lim2_s3 <= lim2_s2;
		mag2_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];

		sq_s4.c    <= c_s3;
		sq_s4.neg  <= neg_s3;
		sq_s4.p    <= p_s3;
		sq_s4.n    <= mag2_s3;
		sq_s4.rem  <= '0;
		sq_s4.root <= '0;
		sq_s4.lim  <= !byp_s3 &&
			(vml_pkg::KW'(mag2_s3) > vml_pkg::KW'(lim2_s3));
	end

	assign sq_v[0] = v_s4;
	assign sq_d[0] = sq_s4;

	for (genvar g = 0; g < CW; g++) begin : g_sqrt
		vml_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_v[g]),
			.in_d      (sq_d[g]),
			.out_valid (sq_v[g+1]),
			.out_d     (sq_d[g+1])
		);
	end

	assign dv_d[0].c   = sq_d[CW].c;
	assign dv_d[0].neg = sq_d[CW].neg;
	assign dv_d[0].lim = sq_d[CW].lim;
	assign dv_d[0].s   = sq_d[CW].root;
	for (genvar i = 0; i < 3; i++) begin : g_ext
		assign dv_d[0].a[i] = vml_pkg::AW'(sq_d[CW].p[i]);
	end
	assign dv_v[0] = sq_v[CW];

	for (genvar g = 0; g < CW; g++) begin : g_div
		vml_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_v[g]),
			.in_d      (dv_d[g]),
			.out_valid (dv_v[g+1]),
			.out_d     (dv_d[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_d[CW].lim) begin
				res[i] = dv_d[CW].neg[i] ? CW'(-dv_d[CW].a[i][CW-1:0])
					: dv_d[CW].a[i][CW-1:0];
			end else begin
				res[i] = dv_d[CW].c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			out_q[i] <= 32'(signed'(res[i]));
		end
		lim_q <= dv_d[CW].lim;
	end

	assign done        = done_q;
	assign out_x       = out_q[0];
	assign out_y       = out_q[1];
	assign out_z       = out_q[2];
	assign was_limited = lim_q;

endmodule
